@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the requantizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)

`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

@@ hw/rtl/accrq_pkg.sv @@
// Types and constants shared by the accumulator requantizer modules.
package accrq_pkg;

   localparam int AccW  = 64;   // accumulator width
   localparam int MulW  = 32;   // multiplier width
   localparam int ShW   = 6;    // shift field width
   localparam int ProdW = 95;   // exact product magnitude width
   localparam int MagW  = 41;   // saturated magnitude width
   localparam int OffW  = 43;   // signed value after offset
   localparam int ResW  = 32;   // result width

   // Largest shift that still scales; anything above gives zero
   localparam logic [ShW-1:0] ShiftLimit = 6'd31;

   // Magnitude saturation point (2^40)
   localparam logic [MagW-1:0] MagCap = 41'h100_0000_0000;

   // Register reset values
   localparam logic [ResW-1:0] ZeroPointReset = 32'h0000_0000;
   localparam logic [ResW-1:0] ClampLowReset  = 32'h8000_0000;
   localparam logic [ResW-1:0] ClampHighReset = 32'h7FFF_FFFF;

   // Register indexes on the CSR port
   typedef enum logic [1:0] {
      CSR_ZERO_POINT = 2'd0,
      CSR_CLAMP_LOW  = 2'd1,
      CSR_CLAMP_HIGH = 2'd2
   } csr_reg_type;

   // Per-item control that travels beside the magnitude
   typedef struct packed {
      logic       neg;     // product sign
      logic       sh_big;  // shift above limit, result forced to zero
      logic [4:0] sh;      // shift amount within limit
   } side_type;

endpackage

@@ hw/rtl/accumulator_requantizer.sv @@
// Accumulator requantizer top level: CSR block, offset and clamp stages.
// Path from req accept to rsp_tvalid: the five accrq_mag stages, then the offset and result registers.
// Throughput: one item per cycle; each of the seven stages takes a new
// item whenever it is empty or its successor takes its item.
// Reset: clears all stage valid bits; zero_point, clamp_low, clamp_high
// return to 0, -2^31 and 2^31-1.
`include "assert_macros.svh"

module accumulator_requantizer (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: accumulator[63:0], scale_multiplier[95:64], right_shift[101:96]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,
   // rsp_tdata: result[31:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic signed [31:0]              zero_point_ff;
   logic signed [31:0]              clamp_low_ff;
   logic signed [31:0]              clamp_high_ff;
   logic                            csr_wr;
   accrq_pkg::csr_reg_type          csr_idx;

   logic                            mag_valid;
   logic                            mag_ready;
   logic [accrq_pkg::MagW-1:0]      mag;
   accrq_pkg::side_type             side;

   logic                            off_valid_ff;
   logic                            res_valid_ff;
   logic                            load_off;
   logic                            load_res;
   logic signed [accrq_pkg::OffW-1:0] mag_ext;
   logic signed [accrq_pkg::OffW-1:0] zp_ext;
   logic signed [accrq_pkg::OffW-1:0] off_in;
   logic signed [accrq_pkg::OffW-1:0] off_ff;
   logic                            zero_in;
   logic                            zero_ff;
   logic signed [accrq_pkg::OffW-1:0] low_ext;
   logic signed [accrq_pkg::OffW-1:0] high_ext;
   logic [31:0]                     res_in;
   logic [31:0]                     res_ff;

   // CSR write and read
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = accrq_pkg::csr_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_point_ff <= accrq_pkg::ZeroPointReset;
         clamp_low_ff  <= accrq_pkg::ClampLowReset;
         clamp_high_ff <= accrq_pkg::ClampHighReset;
      end else if (csr_wr) begin
         unique case (csr_idx)
            accrq_pkg::CSR_ZERO_POINT: zero_point_ff <= csr_pwdata;
            accrq_pkg::CSR_CLAMP_LOW:  clamp_low_ff  <= csr_pwdata;
            accrq_pkg::CSR_CLAMP_HIGH: clamp_high_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         accrq_pkg::CSR_ZERO_POINT: csr_prdata = zero_point_ff;
         accrq_pkg::CSR_CLAMP_LOW:  csr_prdata = clamp_low_ff;
         accrq_pkg::CSR_CLAMP_HIGH: csr_prdata = clamp_high_ff;
         default:                   csr_prdata = 32'h0;
      endcase
   end

   // Product, rounding shift and saturation
   accrq_mag u_mag (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_acc    (req_tdata[63:0]),
      .in_mul    (req_tdata[95:64]),
      .in_shift  (req_tdata[101:96]),
      .out_valid (mag_valid),
      .out_ready (mag_ready),
      .out_mag   (mag),
      .out_side  (side)
   );

   // Stage handshake for offset and clamp stages
   assign load_res  = !res_valid_ff || rsp_tready;
   assign load_off  = !off_valid_ff || load_res;
   assign mag_ready = load_off;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         if (load_off) begin
            off_valid_ff <= mag_valid;
         end
         if (load_res) begin
            res_valid_ff <= off_valid_ff;
         end
      end
   end

   // Stage 6: apply sign and add zero point
   always_comb begin
      mag_ext = {2'b00, mag};
      zp_ext  = {{(accrq_pkg::OffW - 32){zero_point_ff[31]}}, zero_point_ff};
      off_in  = (side.neg ? -mag_ext : mag_ext) + zp_ext;
   end

   // Stage 7: clamp, or zero for an out-of-range shift or inverted bounds
   always_comb begin
      low_ext  = {{(accrq_pkg::OffW - 32){clamp_low_ff[31]}}, clamp_low_ff};
      high_ext = {{(accrq_pkg::OffW - 32){clamp_high_ff[31]}}, clamp_high_ff};
      if (zero_ff || (clamp_low_ff > clamp_high_ff)) begin
         res_in = 32'h0;
      end else if (off_ff < low_ext) begin
         res_in = clamp_low_ff;
      end else if (off_ff > high_ext) begin
         res_in = clamp_high_ff;
      end else begin
         res_in = off_ff[31:0];
      end
   end

   assign zero_in = side.sh_big;

   always_ff @(posedge clock) begin
      if (load_off) begin
         off_ff  <= off_in;
         zero_ff <= zero_in;
      end
      if (load_res) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = res_valid_ff;
   assign rsp_tdata  = res_ff;

   `ASSERT_PROP(a_rsp_held, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped while stalled")
   `ASSERT_PROP(a_zp_written, clock, reset, csr_wr && (csr_idx == accrq_pkg::CSR_ZERO_POINT) |=> zero_point_ff == $past(csr_pwdata), "zero point write lost")
   `ASSERT_PROP(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "result data changed while stalled")

endmodule

@@ hw/rtl/accrq_mag.sv @@
// Five-stage pipeline forming the rounded, saturated product magnitude.
`include "assert_macros.svh"

module accrq_mag (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [accrq_pkg::AccW-1:0]   in_acc,
   input  logic [accrq_pkg::MulW-1:0]   in_mul,
   input  logic [accrq_pkg::ShW-1:0]    in_shift,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [accrq_pkg::MagW-1:0]   out_mag,
   output accrq_pkg::side_type          out_side
);

   localparam int Stages = 5;

   logic [Stages-1:0]           valid_ff;
   logic [Stages-1:0]           valid_in;
   logic [Stages-1:0]           load;
   accrq_pkg::side_type         side_ff [Stages];
   accrq_pkg::side_type         side_in;

   logic [63:0]                 abs_acc_in;
   logic [31:0]                 abs_mul_in;
   logic [63:0]                 abs_acc_ff;
   logic [31:0]                 abs_mul_ff;
   logic [63:0]                 p_lo_in;
   logic [63:0]                 p_hi_in;
   logic [63:0]                 p_lo_ff;
   logic [62:0]                 p_hi_ff;
   logic [accrq_pkg::ProdW-1:0] prod_in;
   logic [accrq_pkg::ProdW-1:0] prod_ff;
   logic [accrq_pkg::ProdW:0]   shq_in;
   logic [accrq_pkg::ProdW:0]   shq_ff;
   logic [accrq_pkg::ProdW:0]   rnd_sum;
   logic [accrq_pkg::ProdW-1:0] rnd_val;
   logic                        sat;
   logic [accrq_pkg::MagW-1:0]  mag_in;
   logic [accrq_pkg::MagW-1:0]  mag_ff;

   // Stage load enables: a stage takes new data when empty or draining
   always_comb begin
      load[Stages-1] = !valid_ff[Stages-1] || out_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in[0] = load[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < Stages; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = load[0];
   assign out_valid = valid_ff[Stages-1];

   // Stage 1: magnitudes, sign and shift fields
   always_comb begin
      abs_acc_in     = in_acc[63] ? (64'd0 - in_acc) : in_acc;
      abs_mul_in     = in_mul[31] ? (32'd0 - in_mul) : in_mul;
      side_in.neg    = in_acc[63] ^ in_mul[31];
      side_in.sh_big = in_shift > accrq_pkg::ShiftLimit;
      side_in.sh     = in_shift[4:0];
   end

   // Stage 2: two 32x32 partial products
   assign p_lo_in = abs_acc_ff[31:0] * abs_mul_ff;
   assign p_hi_in = abs_acc_ff[63:32] * abs_mul_ff;

   // Stage 3: combine partial products into the exact magnitude
   assign prod_in = {p_hi_ff, 32'h0} + {31'h0, p_lo_ff};

   // Stage 4: shift one bit short of the target, keeping the rounding bit
   assign shq_in = {prod_ff, 1'b0} >> side_ff[2].sh;

   // Stage 5: round half up on the magnitude and saturate
   always_comb begin
      rnd_sum = shq_ff + 96'd1;
      rnd_val = rnd_sum[accrq_pkg::ProdW:1];
      sat     = (rnd_val[accrq_pkg::ProdW-1:accrq_pkg::MagW] != '0) ||
                (rnd_val[accrq_pkg::MagW-1:0] > accrq_pkg::MagCap);
      mag_in  = sat ? accrq_pkg::MagCap : rnd_val[accrq_pkg::MagW-1:0];
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (load[0]) begin
         abs_acc_ff <= abs_acc_in;
         abs_mul_ff <= abs_mul_in;
         side_ff[0] <= side_in;
      end
      if (load[1]) begin
         p_lo_ff    <= p_lo_in;
         p_hi_ff    <= p_hi_in[62:0];
         side_ff[1] <= side_ff[0];
      end
      if (load[2]) begin
         prod_ff    <= prod_in;
         side_ff[2] <= side_ff[1];
      end
      if (load[3]) begin
         shq_ff     <= shq_in;
         side_ff[3] <= side_ff[2];
      end
      if (load[4]) begin
         mag_ff     <= mag_in;
         side_ff[4] <= side_ff[3];
      end
   end

   assign out_mag  = mag_ff;
   assign out_side = side_ff[Stages-1];

   `ASSERT_PROP(a_accept_fills, clock, reset, in_valid && in_ready |=> valid_ff[0], "accepted item not in first stage")
   `ASSERT_PROP(a_stall_keeps, clock, reset, out_valid && !out_ready |=> out_valid, "stalled item dropped")
   `ASSERT_PROP(a_mag_capped, clock, reset, out_valid |-> out_mag <= accrq_pkg::MagCap, "magnitude above cap")

endmodule

@@ tb/requant_checker.sv @@
// Checker for the accumulator requantizer: predicts and compares every result item and register read.
module requant_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [103:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [31:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic [31:0]  csr_prdata,
   input  logic         csr_pready,
   output int           error_count,
   output int           results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Local copy of the offset and clamp registers
   logic signed [31:0] zero_point;
   logic signed [31:0] clamp_low;
   logic signed [31:0] clamp_high;

   // Requantized values still waiting on the result channel, oldest first
   logic [31:0] requant_results[$];

   initial begin
      error_count     = 0;
      results_pending = 0;
      zero_point      = accrq_pkg::ZeroPointReset;
      clamp_low       = accrq_pkg::ClampLowReset;
      clamp_high      = accrq_pkg::ClampHighReset;
   end

   // Exact product, rounded magnitude shift, saturate, offset, clamp; 0 if sh > limit or low > high
   function automatic logic [31:0] requantize(logic [63:0] acc, logic [31:0] mul,
                                              logic [5:0] sh);
      logic         acc_neg;
      logic         mul_neg;
      logic [63:0]  acc_mag;
      logic [31:0]  mul_mag;
      logic [127:0] product;
      logic [127:0] rounded;
      logic [40:0]  mag;
      longint       value;
      if (sh > accrq_pkg::ShiftLimit || clamp_low > clamp_high) begin
         return 32'd0;
      end
      acc_neg = acc[63];
      mul_neg = mul[31];
      // magnitudes as unsigned; the most negative values map to 2^63 and 2^31
      acc_mag = acc_neg ? -acc : acc;
      mul_mag = mul_neg ? -mul : mul;
      product = {64'd0, acc_mag} * {96'd0, mul_mag};
      if (sh != 0) begin
         rounded = (product + (128'd1 << (sh - 1))) >> sh;
      end else begin
         rounded = product;
      end
      mag   = (rounded > {87'd0, accrq_pkg::MagCap}) ? accrq_pkg::MagCap : rounded[40:0];
      value = (acc_neg != mul_neg) ? -longint'(mag) : longint'(mag);
      value = value + longint'(zero_point);
      if (value < longint'(clamp_low)) begin
         value = longint'(clamp_low);
      end
      if (value > longint'(clamp_high)) begin
         value = longint'(clamp_high);
      end
      return value[31:0];
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         zero_point  = accrq_pkg::ZeroPointReset;
         clamp_low   = accrq_pkg::ClampLowReset;
         clamp_high  = accrq_pkg::ClampHighReset;
         requant_results.delete();
      end else begin
         // result item against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (requant_results.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_tdata, 32'd0);
            end else if (rsp_tdata !== requant_results[0]) begin
               report_mismatch("result", rsp_tdata, requant_results.pop_front());
            end else begin
               void'(requant_results.pop_front());
            end
         end
         // accepted input item
         if (req_tvalid && req_tready) begin
            requant_results.push_back(requantize(req_tdata[63:0], req_tdata[95:64],
                                                 req_tdata[101:96]));
         end
         // register access
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (accrq_pkg::csr_reg_type'(csr_paddr[3:2]))
                  accrq_pkg::CSR_ZERO_POINT: zero_point = csr_pwdata;
                  accrq_pkg::CSR_CLAMP_LOW:  clamp_low  = csr_pwdata;
                  accrq_pkg::CSR_CLAMP_HIGH: clamp_high = csr_pwdata;
                  default: ;
               endcase
            end else begin
               case (accrq_pkg::csr_reg_type'(csr_paddr[3:2]))
                  accrq_pkg::CSR_ZERO_POINT: begin
                     if (csr_prdata !== zero_point)
                        report_mismatch("zero_point read", csr_prdata, zero_point);
                  end
                  accrq_pkg::CSR_CLAMP_LOW: begin
                     if (csr_prdata !== clamp_low)
                        report_mismatch("clamp_low read", csr_prdata, clamp_low);
                  end
                  accrq_pkg::CSR_CLAMP_HIGH: begin
                     if (csr_prdata !== clamp_high)
                        report_mismatch("clamp_high read", csr_prdata, clamp_high);
                  end
                  default: ;
               endcase
            end
         end
      end
      results_pending = requant_results.size();
   end

endmodule

@@ tb/testbench.sv @@
// Top of the requantizer testbench: clock, reset, stimulus, flow control and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit  = 200000;
   localparam int PhaseItems  = 85;
   localparam int HoldCycles  = 300;
   localparam int SettleCycles = 20;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // req_tdata: accumulator[63:0], scale_multiplier[95:64], right_shift[101:96], zero pad
   logic [103:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // rsp_tdata: result[31:0]
   logic [31:0]  rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int error_count;
   int results_pending;
   int cycle_count = 0;
   int hold_left = 0;     // receiver hold-off, counted down by the receiver
   bit steady = 1'b0;     // no random idling on either side

   accumulator_requantizer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   requant_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .error_count     (error_count),
      .results_pending (results_pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run limit
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Result side: long hold-off on request, else always ready when steady, otherwise random stalls
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 35);
         end
      end
   end

   task automatic csr_write(accrq_pkg::csr_reg_type which, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(accrq_pkg::csr_reg_type which);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {which, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write all three registers and read them back
   task automatic set_output_range(logic [31:0] zp, logic [31:0] lo, logic [31:0] hi);
      csr_write(accrq_pkg::CSR_ZERO_POINT, zp);
      csr_write(accrq_pkg::CSR_CLAMP_LOW, lo);
      csr_write(accrq_pkg::CSR_CLAMP_HIGH, hi);
      csr_read(accrq_pkg::CSR_ZERO_POINT);
      csr_read(accrq_pkg::CSR_CLAMP_LOW);
      csr_read(accrq_pkg::CSR_CLAMP_HIGH);
   endtask

   // Offer one item, with an optional random gap first
   task automatic send_item(logic [63:0] acc, logic [31:0] mul, logic [5:0] sh);
      if (!steady && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, sh, mul, acc};
      do @(posedge clock); while (!req_tready);
   endtask

   // Random item: mostly varied magnitudes and in-range shifts
   task automatic send_random_item();
      int          pick;
      logic [63:0] acc;
      logic [31:0] mul;
      logic [5:0]  sh;
      pick = $urandom_range(99);
      acc  = $signed({$urandom, $urandom}) >>> $urandom_range(63);
      mul  = $signed($urandom) >>> $urandom_range(31);
      sh   = 6'($urandom_range(31));
      if (pick < 10) begin
         sh = 6'($urandom_range(63, 32));
      end else if (pick < 16) begin
         acc = pick[0] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end else if (pick < 20) begin
         mul = pick[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (pick < 30) begin
         acc = {$urandom, $urandom};
         mul = $urandom;
      end
      send_item(acc, mul, sh);
   endtask

   // Stop offering and wait until every result item is back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (results_pending == 0);
      @(posedge clock);
   endtask

   initial begin
      int zp;
      int lo;
      int hi;
      int swap;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values
      csr_read(accrq_pkg::CSR_ZERO_POINT);
      csr_read(accrq_pkg::CSR_CLAMP_LOW);
      csr_read(accrq_pkg::CSR_CLAMP_HIGH);

      // directed items under the reset range
      send_item(64'd0, 32'd0, 6'd0);
      send_item(64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 6'd0);
      send_item(64'h8000_0000_0000_0000, 32'h8000_0000, 6'd31);
      send_item(64'h8000_0000_0000_0000, 32'h7FFF_FFFF, 6'd31);
      send_item(64'h8000_0000_0000_0000, 32'd1, 6'd0);
      send_item(64'd3, 32'd1, 6'd1);                    // 1.5 rounds up
      send_item(-64'sd3, 32'd1, 6'd1);                  // -1.5 rounds away from zero
      send_item(64'd1, 32'd1, 6'd1);
      send_item(-64'sd1, 32'd1, 6'd1);
      send_item(64'd1, 32'hFFFF_FFFF, 6'd2);            // quarter rounds to zero
      send_item(64'd6, 32'd1, 6'd2);
      send_item(64'd12345678, 32'hFFFF_FFFF, 6'd0);
      send_item(64'd100, 32'd100, 6'd32);               // shift just over the limit
      send_item(64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 6'd63);
      send_item(-64'sd1, 32'h8000_0000, 6'd31);
      send_item(64'h100_0000_0000, 32'd1, 6'd0);        // exactly at the saturation point
      send_item(64'h100_0000_0001, 32'd1, 6'd0);
      send_item(-64'sd2147483648, 32'd1, 6'd0);
      send_item(64'h7FFF_FFFF, 32'd1, 6'd0);
      send_item(64'h8000_0000, 32'd1, 6'd0);
      send_item(64'h7FFF_FFFF_FFFF_FFFF, 32'd1, 6'd31);
      send_item({$urandom, $urandom}, 32'h4000_0000, 6'd31);
      drain();

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: set_output_range(32'd5, -32'sd128, 32'sd127);
            1: set_output_range(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
            2: set_output_range(32'h8000_0000, -32'sd1000, 32'sd1000);
            3: set_output_range(-32'sd3, 32'sd10, -32'sd10);   // low bound above high
            4: set_output_range(32'sd7, 32'sd7, 32'sd7);
            5: begin
               zp = $signed($urandom) >>> $urandom_range(31);
               lo = $signed($urandom) >>> $urandom_range(31);
               hi = $signed($urandom) >>> $urandom_range(31);
               if (lo > hi) begin
                  swap = lo;
                  lo   = hi;
                  hi   = swap;
               end
               set_output_range(zp, lo, hi);
            end
            default: set_output_range(accrq_pkg::ZeroPointReset, accrq_pkg::ClampLowReset,
                                      accrq_pkg::ClampHighReset);
         endcase

         // back-pressure: sender keeps offering while the result side holds off
         if (phase == 1) begin
            steady    = 1'b1;
            hold_left = HoldCycles;
         end

         for (int n = 0; n < PhaseItems; n++) begin
            if (phase == 2 && n == PhaseItems / 2) begin
               drain();
            end
            send_random_item();
         end
         drain();
         steady = 1'b0;
      end

      repeat (SettleCycles) @(posedge clock);
      if (error_count == 0 && results_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
